FILE: hdl/kdkt_pkg.sv
// Shared constants and types for the kerf drift Kalman tracker.
package kdkt_pkg;
   localparam int unsigned IO_BITS  = 32;
   localparam int unsigned VAR_BITS = 31;
   localparam int unsigned IDX_BITS = 2;

   localparam logic [IDX_BITS-1:0] REG_TARGET_WIDTH = 2'd0;
   localparam logic [IDX_BITS-1:0] REG_PROCESS_VAR  = 2'd1;
   localparam logic [IDX_BITS-1:0] REG_DRIFT_VAR    = 2'd2;
   localparam logic [IDX_BITS-1:0] REG_MEAS_VAR     = 2'd3;

   typedef logic signed [IO_BITS-1:0] io_word_type;
endpackage

FILE: hdl/kdkt_req_if.sv
// Handshake interface for measurement beats.
interface kdkt_req_if;
   logic valid;
   logic ready;
   logic signed [31:0] measured_width;
   modport source (output valid, output measured_width, input ready);
   modport sink (input valid, input measured_width, output ready);
endinterface

FILE: hdl/kdkt_rsp_if.sv
// Handshake interface for estimate beats.
interface kdkt_rsp_if;
   logic valid;
   logic ready;
   logic signed [31:0] offset_est;
   logic signed [31:0] drift_est;
   logic signed [31:0] innovation;
   modport source (output valid, output offset_est, output drift_est, output innovation,
                   input ready);
   modport sink (input valid, input offset_est, input drift_est, input innovation,
                 output ready);
endinterface

FILE: hdl/kdkt_divider.sv
// Bit-serial restoring fixed-point divider with saturation, one quotient bit per cycle.
module kdkt_divider #(
   parameter int WORD_BITS = 32,
   parameter int FRAC_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic signed [WORD_BITS-1:0] num,
   input  logic signed [WORD_BITS-1:0] den,
   output logic                        done,
   output logic signed [WORD_BITS-1:0] quot
);
   localparam int STEPS = WORD_BITS + FRAC_BITS;
   localparam int CNT_BITS = $clog2(STEPS + 1);
   localparam logic [WORD_BITS:0] MAXM = {2'b00, {(WORD_BITS-1){1'b1}}};

   logic                 busy_ff, busy_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic [WORD_BITS-1:0] n_ff, n_in;
   logic [WORD_BITS+1:0] r_ff, r_in;
   logic [WORD_BITS:0]   d_ff, d_in;
   logic [WORD_BITS:0]   q_ff, q_in;
   logic                 neg_ff, neg_in;
   logic                 done_ff, done_in;
   logic [WORD_BITS+1:0] r_sh;
   logic [WORD_BITS:0]   q_sh;
   logic [WORD_BITS:0]   mag;

   always_comb begin
      busy_in = busy_ff;
      cnt_in = cnt_ff;
      n_in = n_ff;
      r_in = r_ff;
      d_in = d_ff;
      q_in = q_ff;
      neg_in = neg_ff;
      done_in = 1'b0;
      r_sh = {r_ff[WORD_BITS:0], n_ff[WORD_BITS-1]};
      q_sh = {q_ff[WORD_BITS-1:0], 1'b0};
      if (start) begin
         busy_in = 1'b1;
         cnt_in = CNT_BITS'(STEPS);
         n_in = num[WORD_BITS-1] ? -num : num;
         d_in = den[WORD_BITS-1] ? -{den[WORD_BITS-1], den} : {1'b0, den};
         r_in = '0;
         q_in = '0;
         neg_in = num[WORD_BITS-1] ^ den[WORD_BITS-1];
      end else if (busy_ff) begin
         n_in = {n_ff[WORD_BITS-2:0], 1'b0};
         if (r_sh >= {1'b0, d_ff}) begin
            r_in = r_sh - {1'b0, d_ff};
            q_in = q_sh | 1'b1;
         end else begin
            r_in = r_sh;
            q_in = q_sh;
         end
         cnt_in = cnt_ff - 1'b1;
         if (q_in > MAXM) begin
            q_in = MAXM;
            cnt_in = '0;
         end
         if (cnt_in == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      n_ff <= n_in;
      r_ff <= r_in;
      d_ff <= d_in;
      q_ff <= q_in;
      neg_ff <= neg_in;
   end

   assign mag = q_ff;
   assign done = done_ff;
   assign quot = neg_ff ? -mag[WORD_BITS-1:0] : mag[WORD_BITS-1:0];
endmodule

FILE: hdl/kdkt_mac.sv
// Shared fixed-point multiply and saturating add unit, one registered result per cycle.
module kdkt_mac #(
   parameter int WORD_BITS = 32,
   parameter int FRAC_BITS = 16
) (
   input  logic                        clock,
   input  logic                        mul_en,
   input  logic                        sub,
   input  logic                        acc,
   input  logic signed [WORD_BITS-1:0] a,
   input  logic signed [WORD_BITS-1:0] b,
   output logic signed [WORD_BITS-1:0] prod,
   output logic signed [WORD_BITS-1:0] sum
);
   localparam int PW = 2 * WORD_BITS;
   localparam int AW = WORD_BITS + 3;
   localparam logic [PW-1:0] MAXM = PW'({(WORD_BITS-1){1'b1}});

   logic [WORD_BITS-1:0] ma, mb;
   logic [PW-1:0]        p, pr;
   logic                 neg;
   logic [PW-1:0]        mag;
   logic signed [AW-1:0] lhs, acc_ff, acc_in;
   logic signed [WORD_BITS-1:0] prod_ff, prod_in, sum_ff, sum_in;

   always_comb begin
      ma = a[WORD_BITS-1] ? -a : a;
      mb = b[WORD_BITS-1] ? -b : b;
      neg = a[WORD_BITS-1] ^ b[WORD_BITS-1];
      p = PW'(ma) * PW'(mb);
      pr = (p + (PW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
      mag = (pr > MAXM) ? MAXM : pr;
      prod_in = neg ? -WORD_BITS'(mag) : WORD_BITS'(mag);
      lhs = acc ? acc_ff : AW'(a);
      acc_in = sub ? (lhs - AW'(b)) : (lhs + AW'(b));
      if (acc_in[AW-1:WORD_BITS-1] != {(AW-WORD_BITS+1){acc_in[AW-1]}})
         sum_in = acc_in[AW-1] ? {1'b1, {(WORD_BITS-1){1'b0}}}
                               : {1'b0, {(WORD_BITS-1){1'b1}}};
      else
         sum_in = acc_in[WORD_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (mul_en) prod_ff <= prod_in;
      sum_ff <= sum_in;
      acc_ff <= acc_in;
   end

   assign prod = prod_ff;
   assign sum = sum_ff;
endmodule

FILE: hdl/kerf_drift_kalman_tracker_unit.sv
// Top level: sequencer, state registers and configuration of the Kalman tracker.
// Channel | Dir | Payload
// req     | in  | measured_width
// rsp     | out | offset_est, drift_est, innovation
// Each measurement runs from accept through the sequencer steps, including two serial
// divides for the gains. A zero divisor skips both divides.
// Synchronous reset restores registers and filter state. req is ready whenever the sequencer
// is idle; a finished estimate waits in the sequencer until the output register is free
// (empty or being taken), so an untaken estimate there holds the sequencer.
module kerf_drift_kalman_tracker_unit #(
   parameter int WORD_BITS = 32,
   parameter int FRAC_BITS = 16
) (
   input  logic clock,
   input  logic reset,
   kdkt_req_if.sink   req,
   kdkt_rsp_if.source rsp,
   input  logic                            csr_write,
   input  logic [kdkt_pkg::IDX_BITS-1:0]   csr_index,
   input  logic [kdkt_pkg::IO_BITS-1:0]    csr_data
);
   import kdkt_pkg::*;
   typedef logic signed [WORD_BITS-1:0] w_type;

   typedef enum logic [5:0] {
      S_IDLE, S_X0P, S_A1, S_A2, S_A3, S_P00, S_P01, S_P10, S_P11,
      S_I1, S_INN, S_S, S_D0, S_W0, S_D1, S_W1,
      S_M0, S_M0A, S_M1, S_M1A, S_OMK, S_M2, S_M3, S_M4, S_M4A, S_M5, S_M5A, S_OUT,
      S_HOLD
   } state_type;

   localparam w_type ONE = w_type'(1) << FRAC_BITS;
   localparam w_type DD0 = w_type'(((64'd1 << FRAC_BITS) + 64'd50) / 64'd100);

   state_type st_ff;
   w_type tw_ff, pv_ff, dv_ff, mv_ff;
   w_type x0_ff, x1_ff, coo_ff, cod_ff, cdo_ff, cdd_ff;
   w_type x0p_ff, p00_ff, p01_ff, p10_ff, p11_ff, inn_ff, s_ff, k0_ff, k1_ff, omk_ff;
   w_type y_ff;
   w_type ma, mb, prod, sum;
   logic  sub, acc, div_start, div_done;
   w_type dnum, div_den, quot;
   logic  rv_ff;
   io_word_type o0_ff, o1_ff, o2_ff;

   kdkt_mac #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_mac (
      .clock(clock), .mul_en(1'b1), .sub(sub), .acc(acc), .a(ma), .b(mb), .prod(prod),
      .sum(sum));

   kdkt_divider #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_div (
      .clock(clock), .reset(reset), .start(div_start), .num(dnum), .den(div_den),
      .done(div_done), .quot(quot));

   assign req.ready = (st_ff == S_IDLE);
   assign rsp.valid = rv_ff;
   assign rsp.offset_est = o0_ff;
   assign rsp.drift_est = o1_ff;
   assign rsp.innovation = o2_ff;
   assign div_start = ((st_ff == S_D0) && (sum != '0)) || (st_ff == S_D1);
   assign dnum = (st_ff == S_D0) ? p00_ff : p10_ff;
   assign div_den = (st_ff == S_D0) ? sum : s_ff;

   always_comb begin
      ma = '0;
      mb = '0;
      sub = 1'b0;
      acc = 1'b0;
      case (st_ff)
         S_X0P: begin ma = x0_ff; mb = x1_ff; end
         S_A1:  begin ma = coo_ff; mb = cod_ff; end
         S_A2:  begin acc = 1'b1; mb = cdo_ff; end
         S_A3:  begin acc = 1'b1; mb = cdd_ff; end
         S_P00: begin acc = 1'b1; mb = pv_ff; end
         S_P01: begin ma = cod_ff; mb = cdd_ff; end
         S_P10: begin ma = cdo_ff; mb = cdd_ff; end
         S_P11: begin ma = cdd_ff; mb = dv_ff; end
         S_I1:  begin ma = y_ff; mb = tw_ff; sub = 1'b1; end
         S_INN: begin acc = 1'b1; mb = x0p_ff; sub = 1'b1; end
         S_S:   begin ma = p00_ff; mb = mv_ff; end
         S_M0:  begin ma = k0_ff; mb = inn_ff; end
         S_M0A: begin ma = x0p_ff; mb = prod; end
         S_M1:  begin ma = k1_ff; mb = inn_ff; end
         S_M1A: begin ma = x1_ff; mb = prod; end
         S_OMK: begin ma = ONE; mb = k0_ff; sub = 1'b1; end
         S_M2:  begin ma = sum; mb = p00_ff; end
         S_M3:  begin ma = omk_ff; mb = p01_ff; end
         S_M4:  begin ma = k1_ff; mb = p00_ff; end
         S_M4A: begin ma = p10_ff; mb = prod; sub = 1'b1; end
         S_M5:  begin ma = k1_ff; mb = p01_ff; end
         S_M5A: begin ma = p11_ff; mb = prod; sub = 1'b1; end
         default: begin ma = '0; mb = '0; end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
         rv_ff <= 1'b0;
         tw_ff <= w_type'(signed'(32'sd3604480));
         pv_ff <= w_type'(2621);
         dv_ff <= w_type'(7);
         mv_ff <= w_type'(41943);
         x0_ff <= '0;
         x1_ff <= '0;
         coo_ff <= ONE;
         cod_ff <= '0;
         cdo_ff <= '0;
         cdd_ff <= DD0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               REG_TARGET_WIDTH: tw_ff <= w_type'(signed'(csr_data));
               REG_PROCESS_VAR:  pv_ff <= w_type'({1'b0, csr_data[VAR_BITS-1:0]});
               REG_DRIFT_VAR:    dv_ff <= w_type'({1'b0, csr_data[VAR_BITS-1:0]});
               REG_MEAS_VAR:     mv_ff <= w_type'({1'b0, csr_data[VAR_BITS-1:0]});
               default: ;
            endcase
         end
         if (rsp.valid && rsp.ready && (st_ff != S_HOLD)) rv_ff <= 1'b0;
         case (st_ff)
            S_IDLE: if (req.valid && req.ready) begin
               y_ff <= w_type'(req.measured_width);
               st_ff <= S_X0P;
            end
            S_X0P: st_ff <= S_A1;
            S_A1:  begin x0p_ff <= sum; st_ff <= S_A2; end
            S_A2:  st_ff <= S_A3;
            S_A3:  st_ff <= S_P00;
            S_P00: st_ff <= S_P01;
            S_P01: begin p00_ff <= sum; st_ff <= S_P10; end
            S_P10: begin p01_ff <= sum; st_ff <= S_P11; end
            S_P11: begin p10_ff <= sum; st_ff <= S_I1; end
            S_I1:  begin p11_ff <= sum; st_ff <= S_INN; end
            S_INN: st_ff <= S_S;
            S_S:   begin inn_ff <= sum; st_ff <= S_D0; end
            S_D0:  begin
               s_ff <= sum;
               if (sum == '0) begin
                  k0_ff <= '0;
                  k1_ff <= '0;
                  st_ff <= S_M0;
               end else begin
                  st_ff <= S_W0;
               end
            end
            S_W0:  if (div_done) begin k0_ff <= quot; st_ff <= S_D1; end
            S_D1:  st_ff <= S_W1;
            S_W1:  if (div_done) begin k1_ff <= quot; st_ff <= S_M0; end
            S_M0:  st_ff <= S_M0A;
            S_M0A: st_ff <= S_M1;
            S_M1:  begin x0_ff <= sum; st_ff <= S_M1A; end
            S_M1A: st_ff <= S_OMK;
            S_OMK: begin x1_ff <= sum; st_ff <= S_M2; end
            S_M2:  begin omk_ff <= sum; st_ff <= S_M3; end
            S_M3:  begin coo_ff <= prod; st_ff <= S_M4; end
            S_M4:  begin cod_ff <= prod; st_ff <= S_M4A; end
            S_M4A: st_ff <= S_M5;
            S_M5:  begin cdo_ff <= sum; st_ff <= S_M5A; end
            S_M5A: st_ff <= S_OUT;
            S_OUT: begin
               cdd_ff <= sum;
               st_ff <= S_HOLD;
            end
            S_HOLD: if (!rv_ff || rsp.ready) begin
               o0_ff <= io_word_type'(x0_ff);
               o1_ff <= io_word_type'(x1_ff);
               o2_ff <= io_word_type'(inn_ff);
               rv_ff <= 1'b1;
               st_ff <= S_IDLE;
            end
            default: st_ff <= S_IDLE;
         endcase
      end
   end
endmodule
